>>> sv/slp_pkg.sv
// Shared types and constants of the serial memory loader parser.
`timescale 1ns / 1ps

package slp_pkg;

  // Kinds of result that the parser reports.
  typedef enum logic [2:0] {
    K_WRITE = 3'd0,
    K_CSUM  = 3'd1,
    K_DONE  = 3'd2,
    K_JUMP  = 3'd3,
    K_FAST  = 3'd4
  } kind_t;

  // Record headers with a meaning of their own.
  localparam logic [7:0] HDR_DONE = 8'hFF;
  localparam logic [7:0] HDR_JUMP = 8'hFE;
  localparam logic [7:0] HDR_FAST = 8'hFD;

  // Load address after reset, before masking to the address width.
  localparam logic [31:0] RESET_ADDR = 32'h0012_3456;

  // Offset added to the count in the record checksum.
  localparam logic [7:0] CSUM_OFFSET = 8'd5;

  // Result queue geometry.
  localparam int QDEPTH     = 8;
  localparam int QPTR_BITS  = $clog2(QDEPTH);
  localparam int QCNT_BITS  = $clog2(QDEPTH + 1);
  // Room left for the byte in the input register and the next one.
  localparam int QACCEPT_MAX = QDEPTH - 4;

  // Results of one byte handed from the parser to the queue.
  typedef struct packed {
    logic [1:0] cnt;
    kind_t      k0;
    kind_t      k1;
  } slp_push_t;

endpackage

>>> sv/slp_parser.sv
// Record parser: protocol state and the decode of one received byte.
`timescale 1ns / 1ps

module slp_parser #(
  parameter int ADDRESS_BITS = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               byte_valid,
  input  logic [7:0]         rx_byte,
  output slp_pkg::slp_push_t push
);
  import slp_pkg::*;

  typedef enum logic [2:0] {
    PH_HEADER = 3'b001,
    PH_ADDR   = 3'b010,
    PH_DATA   = 3'b100
  } phase_t;

  phase_t                  phase_r, phase_nxt;
  logic [1:0]              idx_r, idx_nxt;
  logic                    jump_r, jump_nxt;
  logic [ADDRESS_BITS-1:0] addr_r, addr_nxt;
  logic [5:0]              rem_r, rem_nxt;
  logic [7:0]              sum_r, sum_nxt;
  logic                    halted_r, halted_nxt;

  logic [31:0]             addr_word;
  logic [ADDRESS_BITS-1:0] addr_ins;
  logic [ADDRESS_BITS-1:0] addr_hdr;
  logic [5:0]              rem_dec;

  // Checksum seed: the four address bytes, the count and the fixed offset.
  function automatic logic [7:0] csum_seed(input logic [31:0] w, input logic [5:0] cnt);
    logic [7:0] s;
    s = w[31:24] + w[23:16] + w[15:8] + w[7:0];
    return s + {2'b00, cnt} + CSUM_OFFSET;
  endfunction

  // Address with the incoming byte placed in the byte lane that is due.
  always_comb begin
    addr_word = 32'(addr_r);
    unique case (idx_r)
      2'd0: addr_word[31:24] = rx_byte;
      2'd1: addr_word[23:16] = rx_byte;
      2'd2: addr_word[15:8]  = rx_byte;
      2'd3: addr_word[7:0]   = rx_byte;
      default: addr_word = 32'(addr_r);
    endcase
    addr_ins = addr_word[ADDRESS_BITS-1:0];
    addr_hdr = rx_byte[6] ? addr_r + 1'b1 : addr_r;
    rem_dec  = rem_r - 6'd1;
  end

  // Next state and results of one byte.
  always_comb begin
    phase_nxt  = phase_r;
    idx_nxt    = idx_r;
    jump_nxt   = jump_r;
    addr_nxt   = addr_r;
    rem_nxt    = rem_r;
    sum_nxt    = sum_r;
    halted_nxt = halted_r;
    push.cnt   = 2'd0;
    push.k0    = K_WRITE;
    push.k1    = K_WRITE;
    if (byte_valid && !halted_r) begin
      unique case (phase_r)
        PH_HEADER: begin
          priority if (rx_byte == HDR_DONE) begin
            halted_nxt = 1'b1;
            push.cnt   = 2'd1;
            push.k0    = K_DONE;
          end else if (rx_byte == HDR_JUMP) begin
            jump_nxt  = 1'b1;
            idx_nxt   = 2'd0;
            phase_nxt = PH_ADDR;
          end else if (rx_byte == HDR_FAST) begin
            push.cnt = 2'd1;
            push.k0  = K_FAST;
          end else if (rx_byte[7]) begin
            jump_nxt  = 1'b0;
            rem_nxt   = rx_byte[5:0];
            idx_nxt   = 2'd0;
            phase_nxt = PH_ADDR;
          end else begin
            addr_nxt = addr_hdr;
            rem_nxt  = rx_byte[5:0];
            sum_nxt  = csum_seed(32'(addr_hdr), rx_byte[5:0]);
            if (rx_byte[5:0] == 6'd0) begin
              phase_nxt = PH_HEADER;
              push.cnt  = 2'd1;
              push.k0   = K_CSUM;
            end else begin
              phase_nxt = PH_DATA;
            end
          end
        end
        PH_ADDR: begin
          addr_nxt = addr_ins;
          if (idx_r == 2'd3) begin
            idx_nxt = 2'd0;
            if (jump_r) begin
              jump_nxt   = 1'b0;
              phase_nxt  = PH_HEADER;
              halted_nxt = 1'b1;
              push.cnt   = 2'd1;
              push.k0    = K_JUMP;
            end else begin
              sum_nxt = csum_seed(32'(addr_ins), rem_r);
              if (rem_r == 6'd0) begin
                phase_nxt = PH_HEADER;
                push.cnt  = 2'd1;
                push.k0   = K_CSUM;
              end else begin
                phase_nxt = PH_DATA;
              end
            end
          end else begin
            idx_nxt = idx_r + 2'd1;
          end
        end
        PH_DATA: begin
          addr_nxt = addr_r + 1'b1;
          sum_nxt  = sum_r + rx_byte;
          rem_nxt  = rem_dec;
          push.cnt = 2'd1;
          push.k0  = K_WRITE;
          if (rem_dec == 6'd0) begin
            phase_nxt = PH_HEADER;
            push.cnt  = 2'd2;
            push.k1   = K_CSUM;
          end
        end
        default: phase_nxt = PH_HEADER;
      endcase
    end
  end

  // Protocol state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HEADER;
      idx_r    <= 2'd0;
      jump_r   <= 1'b0;
      addr_r   <= RESET_ADDR[ADDRESS_BITS-1:0];
      rem_r    <= 6'd0;
      sum_r    <= 8'd0;
      halted_r <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      idx_r    <= idx_nxt;
      jump_r   <= jump_nxt;
      addr_r   <= addr_nxt;
      rem_r    <= rem_nxt;
      sum_r    <= sum_nxt;
      halted_r <= halted_nxt;
    end
  end

`ifndef SYNTHESIS
  // Once halted the parser stays halted and reports nothing more.
  a_halt_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    halted_r |=> halted_r) else $error("parser left the halted state");
  a_halt_silent: assert property (@(posedge clk) disable iff (!rst_n)
    halted_r |-> push.cnt == 2'd0) else $error("result reported while halted");
  // Address bytes are only counted while the address phase is active.
  a_idx_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != PH_ADDR) |-> idx_r == 2'd0) else $error("address index outside address phase");
`endif

endmodule

>>> sv/slp_outq.sv
// Result queue: takes up to two results a cycle, delivers one a cycle while out_ready is high.
`timescale 1ns / 1ps

module slp_outq (
  input  logic                        clk,
  input  logic                        rst_n,
  input  slp_pkg::slp_push_t          push,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [2:0]                  out_kind,
  output logic [slp_pkg::QCNT_BITS-1:0] level
);
  import slp_pkg::*;

  kind_t                 mem_r [QDEPTH];
  logic [QPTR_BITS-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_BITS-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_BITS-1:0]  cnt_r, cnt_nxt;
  logic [QPTR_BITS-1:0]  wr_ptr_1;
  logic                  pop;

  assign out_valid = (cnt_r != '0);
  assign out_kind  = mem_r[rd_ptr_r];
  assign level     = cnt_r;
  assign pop       = out_valid && out_ready;
  assign wr_ptr_1  = wr_ptr_r + 1'b1;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + QPTR_BITS'(push.cnt);
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + QCNT_BITS'(push.cnt) - QCNT_BITS'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Result storage; the second result of a byte goes to the following slot.
  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem_r[wr_ptr_r] <= push.k0;
    end
    if (push.cnt == 2'd2) begin
      mem_r[wr_ptr_1] <= push.k1;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCNT_BITS'(QDEPTH)) else $error("result queue overflow");
  a_push_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    push.cnt != 2'd3) else $error("more than two results from one request");
`endif

endmodule

>>> sv/serial_memory_loader_parser.sv
// Top level of the serial memory loader parser.
`timescale 1ns / 1ps

// Takes one received serial byte per clock cycle while in_ready is high and
// reports, as a stream of result kinds, what each byte of the upload protocol
// causes: memory writes, checksum replies, done, jump and fast baud requests.
// A byte is registered on acceptance, decoded in the next cycle and its
// results enter an eight-entry queue. Most bytes give at most one result; the
// last data byte of a record gives two, which leave the output port one after
// the other. Input is taken while the queue holds four results or fewer, so
// with a ready consumer the block sustains one byte per cycle, bounded in the
// long run by one result per cycle at the output. After done or jump every
// accepted byte is ignored until reset.
module serial_memory_loader_parser #(
  parameter int ADDRESS_BITS = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] out_kind
);
  import slp_pkg::*;

  logic                 stage_v_r;
  logic [7:0]           stage_b_r;
  slp_push_t            push;
  logic [QCNT_BITS-1:0] level;

  // Accept while the queue has room for this request and the one in the register.
  assign in_ready = (level <= QCNT_BITS'(QACCEPT_MAX));

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_v_r <= 1'b0;
    end else begin
      stage_v_r <= in_valid && in_ready;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_b_r <= in_rx_byte;
    end
  end

  slp_parser #(
    .ADDRESS_BITS(ADDRESS_BITS)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_valid(stage_v_r),
    .rx_byte   (stage_b_r),
    .push      (push)
  );

  slp_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_kind (out_kind),
    .level    (level)
  );

`ifndef SYNTHESIS
  // A request is never taken when the queue could not hold its results.
  a_accept_room: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |-> level <= QCNT_BITS'(QACCEPT_MAX))
    else $error("request accepted without queue room");
`endif

endmodule
